// ===== src/tse_pkg.sv =====
// Shared types, widths and constants of the Taylor sine evaluator.
// Holds the per-term reciprocal table; no dependencies.

package tse_pkg;

	localparam int TERM_COUNT  = 8;
	localparam int TERM_LIMIT  = 16;

	localparam int ANGLE_W     = 32;
	localparam int SINE_W      = 40;
	localparam int X2_W        = 64;
	localparam int MAG_W       = 57;
	localparam int P_W         = 63;
	localparam int ACC_W       = 60;
	localparam int RECIP_W     = 64;
	localparam int HALF        = 32;
	localparam int PROD_W      = 128;
	localparam int X2_FRAC     = 58;
	localparam int FIRST_SHIFT = 19;
	localparam int OUT_SHIFT   = 17;

	typedef logic        [ANGLE_W-1:0] angle_t;
	typedef logic signed [SINE_W-1:0]  sine_t;
	typedef logic        [X2_W-1:0]    x2_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic        [P_W-1:0]     p_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic        [RECIP_W-1:0] recip_t;
	typedef logic        [2*HALF-1:0]  part_t;
	typedef logic        [PROD_W-1:0]  prod_t;

	typedef struct packed {
		logic vld;
		x2_t  x2;
		mag_t mag;
		acc_t acc;
	} cell_bus_t;

	localparam recip_t RECIP_NUM = {RECIP_W{1'b1}};

	// floor((2^64 - 1) / (2i(2i+1))), entry i; entry zero unused
	localparam recip_t RECIP_TAB [TERM_LIMIT] = '{
		'0,
		RECIP_NUM / 64'd6,
		RECIP_NUM / 64'd20,
		RECIP_NUM / 64'd42,
		RECIP_NUM / 64'd72,
		RECIP_NUM / 64'd110,
		RECIP_NUM / 64'd156,
		RECIP_NUM / 64'd210,
		RECIP_NUM / 64'd272,
		RECIP_NUM / 64'd342,
		RECIP_NUM / 64'd420,
		RECIP_NUM / 64'd506,
		RECIP_NUM / 64'd600,
		RECIP_NUM / 64'd702,
		RECIP_NUM / 64'd812,
		RECIP_NUM / 64'd930
	};

	localparam logic LAST_SUB = ((TERM_COUNT - 1) % 2) == 1;

	localparam acc_t SAT_HI = {{(ACC_W-SINE_W+1){1'b0}}, {(SINE_W-1){1'b1}}};
	localparam acc_t SAT_LO = {{(ACC_W-SINE_W+1){1'b1}}, {(SINE_W-1){1'b0}}};

endpackage

// ===== src/tse_angle_if.sv =====
// Input channel of the Taylor sine evaluator: valid/ready with one angle per beat.
// Depends on tse_pkg.

interface tse_angle_if;
	import tse_pkg::*;
	logic   valid;
	logic   ready;
	angle_t angle;

	modport source(output valid, output angle, input ready);
	modport sink(input valid, input angle, output ready);
endinterface

// ===== src/tse_sine_if.sv =====
// Output channel of the Taylor sine evaluator: valid/ready with one sine per beat.
// Depends on tse_pkg.

interface tse_sine_if;
	import tse_pkg::*;
	logic  valid;
	logic  ready;
	sine_t sine_value;

	modport source(output valid, output sine_value, input ready);
	modport sink(input valid, input sine_value, output ready);
endinterface

// ===== src/tse_cell.sv =====
// One series cell: folds the incoming term into the sum and derives the next term
// through two split 64-bit products over four stages. Depends on tse_pkg.

module tse_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  tse_pkg::recip_t    recip,
	input  logic               sub,
	input  tse_pkg::cell_bus_t up,
	output tse_pkg::cell_bus_t dn
);
	import tse_pkg::*;

	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	x2_t   x2_s1, x2_s2, x2_s3, x2_s4;
	acc_t  acc_s1, acc_s2, acc_s3, acc_s4;
	part_t pa0_s1, pa1_s1, pa2_s1, pa3_s1;
	p_t    p_s2;
	part_t pb0_s3, pb1_s3, pb2_s3, pb3_s3;
	mag_t  mag_s4;
	prod_t sum_a, sum_b;

	always_comb begin
		sum_a = (prod_t'(pa3_s1) << (2*HALF)) + (prod_t'(pa1_s1) << HALF)
			+ (prod_t'(pa2_s1) << HALF) + prod_t'(pa0_s1);
		sum_b = (prod_t'(pb3_s3) << (2*HALF)) + (prod_t'(pb1_s3) << HALF)
			+ (prod_t'(pb2_s3) << HALF) + prod_t'(pb0_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1  <= up.x2;
			acc_s1 <= sub ? up.acc - acc_t'(up.mag) : up.acc + acc_t'(up.mag);
			pa0_s1 <= part_t'(up.mag[HALF-1:0]) * part_t'(up.x2[HALF-1:0]);
			pa1_s1 <= part_t'(up.mag[HALF-1:0]) * part_t'(up.x2[X2_W-1:HALF]);
			pa2_s1 <= part_t'(up.mag[MAG_W-1:HALF]) * part_t'(up.x2[HALF-1:0]);
			pa3_s1 <= part_t'(up.mag[MAG_W-1:HALF]) * part_t'(up.x2[X2_W-1:HALF]);

			x2_s2  <= x2_s1;
			acc_s2 <= acc_s1;
			p_s2   <= sum_a[X2_FRAC +: P_W];

			x2_s3  <= x2_s2;
			acc_s3 <= acc_s2;
			pb0_s3 <= part_t'(p_s2[HALF-1:0]) * part_t'(recip[HALF-1:0]);
			pb1_s3 <= part_t'(p_s2[HALF-1:0]) * part_t'(recip[RECIP_W-1:HALF]);
			pb2_s3 <= part_t'(p_s2[P_W-1:HALF]) * part_t'(recip[HALF-1:0]);
			pb3_s3 <= part_t'(p_s2[P_W-1:HALF]) * part_t'(recip[RECIP_W-1:HALF]);

			x2_s4  <= x2_s3;
			acc_s4 <= acc_s3;
			mag_s4 <= sum_b[RECIP_W +: MAG_W];
		end
	end

	always_comb begin
		dn.vld = vld_s4;
		dn.x2  = x2_s4;
		dn.mag = mag_s4;
		dn.acc = acc_s4;
	end

endmodule

// ===== src/tse_tail.sv =====
// Final fold of the last term, floor shift to Q8.31 with saturation, and the
// output register with its skid slot. Depends on tse_pkg and tse_sine_if.

module tse_tail (
	input  logic               clk,
	input  logic               arst_n,
	input  tse_pkg::cell_bus_t up,
	output logic               en,
	tse_sine_if.source         results
);
	import tse_pkg::*;

	logic  vld_t1;
	acc_t  acc_t1;
	acc_t  shifted;
	sine_t sat;
	logic  out_vld_q, skid_vld_q;
	sine_t out_q, skid_q;
	logic  arrive, pop;

	assign en     = !skid_vld_q;
	assign arrive = vld_t1 && en;
	assign pop    = out_vld_q && results.ready;

	always_comb begin
		shifted = acc_t1 >>> OUT_SHIFT;
		if (shifted > SAT_HI) begin
			sat = SAT_HI[SINE_W-1:0];
		end else if (shifted < SAT_LO) begin
			sat = SAT_LO[SINE_W-1:0];
		end else begin
			sat = shifted[SINE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1 <= 1'b0;
		end else if (en) begin
			vld_t1 <= up.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_t1 <= LAST_SUB ? up.acc - acc_t'(up.mag) : up.acc + acc_t'(up.mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= arrive;
			end else begin
				out_vld_q <= arrive;
			end
		end else if (arrive) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_q  <= skid_q;
				skid_q <= sat;
			end else begin
				out_q <= sat;
			end
		end else if (arrive) begin
			skid_q <= sat;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.sine_value = out_q;

endmodule

// ===== src/taylor_sine_evaluator.sv =====
// Top level of the Taylor sine evaluator: squaring head, row of series cells, tail.
// Depends on tse_pkg, tse_angle_if, tse_sine_if, tse_cell and tse_tail.

// Takes one angle per clock (unsigned Q3.29) and returns the sine as the sum of
// TERM_COUNT Taylor terms, signed Q8.31, saturated, results in input order. The
// datapath is a row of TERM_COUNT-1 identical cells, one per term after the
// first, each four stages deep; an angle passes the squaring register, the cells,
// the tail's fold register and the output register. A full pipeline sustains one
// beat per cycle; a stalled output holds one result in its skid slot and then
// stops input until the sink drains it. No state is kept between items.

module taylor_sine_evaluator (
	input logic        clk,
	input logic        arst_n,
	tse_angle_if.sink   samples,
	tse_sine_if.source  results
);
	import tse_pkg::*;

	logic      en;
	logic      vld_s0;
	x2_t       x2_s0;
	angle_t    angle_s0;
	cell_bus_t bus [TERM_COUNT];

	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s0    <= x2_t'(samples.angle) * x2_t'(samples.angle);
			angle_s0 <= samples.angle;
		end
	end

	always_comb begin
		bus[0].vld = vld_s0;
		bus[0].x2  = x2_s0;
		bus[0].mag = mag_t'(angle_s0) << FIRST_SHIFT;
		bus[0].acc = '0;
	end

	for (genvar k = 1; k < TERM_COUNT; k++) begin : g_cell
		tse_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.recip  (RECIP_TAB[k]),
			.sub    ((k % 2) == 0),
			.up     (bus[k-1]),
			.dn     (bus[k])
		);
	end

	tse_tail u_tail (
		.clk     (clk),
		.arst_n  (arst_n),
		.up      (bus[TERM_COUNT-1]),
		.en      (en),
		.results (results)
	);

endmodule
